### rtl/c2eu_pkg.sv
package c2eu_pkg;

  typedef enum logic [4:0] {
    OP_LD   = 5'd0,
    OP_LAD  = 5'd1,
    OP_ST   = 5'd2,
    OP_ADDA = 5'd3,
    OP_SUBA = 5'd4,
    OP_ADDL = 5'd5,
    OP_SUBL = 5'd6,
    OP_AND  = 5'd7,
    OP_OR   = 5'd8,
    OP_XOR  = 5'd9,
    OP_CPA  = 5'd10,
    OP_CPL  = 5'd11,
    OP_SLA  = 5'd12,
    OP_SRA  = 5'd13,
    OP_SLL  = 5'd14,
    OP_SRL  = 5'd15,
    OP_JMI  = 5'd16,
    OP_JNZ  = 5'd17,
    OP_JZE  = 5'd18,
    OP_JUMP = 5'd19,
    OP_JPL  = 5'd20,
    OP_JOV  = 5'd21
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_REG_A = 2'd1,
    ERR_REG_B = 2'd2,
    ERR_ADDR  = 2'd3
  } err_e;

  localparam logic        ADDR_MEM_SIZE = 1'b0;
  localparam logic [16:0] MEM_SIZE_RST  = 17'h10000;
  localparam logic [4:0]  SHIFT_MAX     = 5'd16;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic        use_register;
    logic [15:0] address;
    logic [15:0] mem_value;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [15:0] eff_address;
    logic        reg_written;
    logic        overflow_flag;
    logic        sign_flag;
    logic        zero_flag;
    logic        branch_taken;
    logic [1:0]  error_code;
  } out_beat_t;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
  } flags_t;

  typedef struct packed {
    logic        reg_we;
    logic [3:0]  reg_addr;
    logic [15:0] reg_data;
    logic        flag_we;
    flags_t      flags;
  } wb_t;

  function automatic flags_t sz_flags(input logic [15:0] v);
    flags_t f;
    f.of = 1'b0;
    f.sf = v[15];
    f.zf = (v == 16'h0000);
    return f;
  endfunction

endpackage

### rtl/c2eu_regfile.sv
module c2eu_regfile #(
  parameter int REG_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [3:0]       ra_addr_i,
  input  logic [3:0]       rb_addr_i,
  input  c2eu_pkg::wb_t    wb_i,
  output logic [15:0]      ra_data_o,
  output logic [15:0]      rb_data_o
);

  localparam int         IdxW  = $clog2(REG_COUNT);
  localparam logic [4:0] Count = 5'(REG_COUNT);

  logic [15:0]          mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [15:0]          ra_q;
  logic [15:0]          rb_q;

  function automatic logic [15:0] rd(input logic [3:0] addr);
    logic [15:0] v;
    v = '0;
    if (wb_i.reg_we && (wb_i.reg_addr == addr)) begin
      v = wb_i.reg_data;
    end else if (({1'b0, addr} < Count) && vld_q[addr[IdxW-1:0]]) begin
      v = mem_q[addr[IdxW-1:0]];
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wb_i.reg_we) begin
      vld_q[wb_i.reg_addr[IdxW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_i.reg_we) begin
      mem_q[wb_i.reg_addr[IdxW-1:0]] <= wb_i.reg_data;
    end
    if (rd_en_i) begin
      ra_q <= rd(ra_addr_i);
      rb_q <= rd(rb_addr_i);
    end
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

### rtl/c2eu_alu.sv
module c2eu_alu #(
  parameter int REG_COUNT = 8
) (
  input  c2eu_pkg::in_beat_t  item_i,
  input  logic [15:0]         ra_val_i,
  input  logic [15:0]         rb_val_i,
  input  c2eu_pkg::flags_t    flags_i,
  input  logic [16:0]         mem_size_i,
  output c2eu_pkg::out_beat_t res_o,
  output c2eu_pkg::wb_t       wb_o
);

  localparam logic [4:0] Count = 5'(REG_COUNT);

  c2eu_pkg::op_e    op;
  c2eu_pkg::err_e   err;
  c2eu_pkg::flags_t nf;
  logic        known, alu_op, regform, memacc, ra_ok, rb_ok, active;
  logic [15:0] idx, ea, a, b, res;
  logic [4:0]  n;
  logic [16:0] sum_s, dif_s, sum_u;
  logic [15:0] sla_t;
  logic [16:0] sra_t, sll_t, srl_t;
  logic        wr, br, last, is_shift;

  always_comb begin
    op      = c2eu_pkg::op_e'(item_i.req_type);
    known   = (item_i.req_type <= c2eu_pkg::OP_JOV);
    alu_op  = (op == c2eu_pkg::OP_LD) ||
              ((op >= c2eu_pkg::OP_ADDA) && (op <= c2eu_pkg::OP_CPL));
    regform = alu_op && item_i.use_register;
    memacc  = (alu_op && !regform) || (op == c2eu_pkg::OP_ST);
    ra_ok   = ({1'b0, item_i.reg_a} < Count);
    rb_ok   = ({1'b0, item_i.reg_b} < Count);
    idx     = (rb_ok && (item_i.reg_b != 4'd0)) ? rb_val_i : 16'h0000;
    ea      = item_i.address + idx;

    err = c2eu_pkg::ERR_NONE;
    if (known) begin
      if ((item_i.req_type <= c2eu_pkg::OP_SRL) && !ra_ok) begin
        err = c2eu_pkg::ERR_REG_A;
      end else if (!rb_ok) begin
        err = c2eu_pkg::ERR_REG_B;
      end else if (memacc && ({1'b0, ea} >= mem_size_i)) begin
        err = c2eu_pkg::ERR_ADDR;
      end
    end
    active = known && (err == c2eu_pkg::ERR_NONE);

    a = ra_val_i;
    b = regform ? rb_val_i : item_i.mem_value;
    n = (ea > 16'(c2eu_pkg::SHIFT_MAX)) ? c2eu_pkg::SHIFT_MAX : ea[4:0];

    sum_s = {a[15], a} + {b[15], b};
    dif_s = {a[15], a} - {b[15], b};
    sum_u = {1'b0, a} + {1'b0, b};
    sla_t = {1'b0, a[14:0]} << n;
    sra_t = 17'($signed({a, 1'b0}) >>> n);
    sll_t = {1'b0, a} << n;
    srl_t = {a, 1'b0} >> n;

    res      = 16'h0000;
    wr       = 1'b0;
    br       = 1'b0;
    last     = 1'b0;
    is_shift = 1'b0;
    nf       = flags_i;
    case (op)
      c2eu_pkg::OP_LD: begin
        res = b;
        wr  = 1'b1;
        nf  = c2eu_pkg::sz_flags(res);
      end
      c2eu_pkg::OP_LAD: begin
        res = ea;
        wr  = 1'b1;
      end
      c2eu_pkg::OP_ST: begin
        res = a;
      end
      c2eu_pkg::OP_ADDA: begin
        res   = sum_s[15:0];
        wr    = 1'b1;
        nf    = c2eu_pkg::sz_flags(res);
        nf.of = sum_s[16] ^ sum_s[15];
      end
      c2eu_pkg::OP_SUBA: begin
        res   = dif_s[15:0];
        wr    = 1'b1;
        nf    = c2eu_pkg::sz_flags(res);
        nf.of = dif_s[16] ^ dif_s[15];
      end
      c2eu_pkg::OP_ADDL: begin
        res   = sum_u[15:0];
        wr    = 1'b1;
        nf    = c2eu_pkg::sz_flags(res);
        nf.of = sum_u[16];
      end
      c2eu_pkg::OP_SUBL: begin
        res   = a - b;
        wr    = 1'b1;
        nf    = c2eu_pkg::sz_flags(res);
        nf.of = (a < b);
      end
      c2eu_pkg::OP_AND: begin
        res = a & b;
        wr  = 1'b1;
        nf  = c2eu_pkg::sz_flags(res);
      end
      c2eu_pkg::OP_OR: begin
        res = a | b;
        wr  = 1'b1;
        nf  = c2eu_pkg::sz_flags(res);
      end
      c2eu_pkg::OP_XOR: begin
        res = a ^ b;
        wr  = 1'b1;
        nf  = c2eu_pkg::sz_flags(res);
      end
      c2eu_pkg::OP_CPA: begin
        nf.of = 1'b0;
        nf.sf = ($signed(a) < $signed(b));
        nf.zf = !nf.sf && (a == b);
      end
      c2eu_pkg::OP_CPL: begin
        nf.of = 1'b0;
        nf.sf = (a < b);
        nf.zf = !nf.sf && (a == b);
      end
      c2eu_pkg::OP_SLA: begin
        res      = {a[15], sla_t[14:0]};
        last     = sla_t[15];
        wr       = 1'b1;
        is_shift = 1'b1;
      end
      c2eu_pkg::OP_SRA: begin
        res      = {a[15], sra_t[15:1]};
        last     = sra_t[0];
        wr       = 1'b1;
        is_shift = 1'b1;
      end
      c2eu_pkg::OP_SLL: begin
        res      = sll_t[15:0];
        last     = sll_t[16];
        wr       = 1'b1;
        is_shift = 1'b1;
      end
      c2eu_pkg::OP_SRL: begin
        res      = srl_t[16:1];
        last     = srl_t[0];
        wr       = 1'b1;
        is_shift = 1'b1;
      end
      c2eu_pkg::OP_JMI:  br = flags_i.sf;
      c2eu_pkg::OP_JNZ:  br = !flags_i.zf;
      c2eu_pkg::OP_JZE:  br = flags_i.zf;
      c2eu_pkg::OP_JUMP: br = 1'b1;
      c2eu_pkg::OP_JPL:  br = !flags_i.sf && !flags_i.zf;
      c2eu_pkg::OP_JOV:  br = flags_i.of;
      default: begin
        res = 16'h0000;
      end
    endcase

    if (is_shift) begin
      nf    = c2eu_pkg::sz_flags(res);
      nf.of = last;
    end

    if (!active) begin
      res = 16'h0000;
      wr  = 1'b0;
      br  = 1'b0;
      nf  = flags_i;
    end

    res_o.result_value  = res;
    res_o.eff_address   = regform ? 16'h0000 : ea;
    res_o.reg_written   = wr;
    res_o.overflow_flag = nf.of;
    res_o.sign_flag     = nf.sf;
    res_o.zero_flag     = nf.zf;
    res_o.branch_taken  = br;
    res_o.error_code    = err;

    wb_o.reg_we   = wr;
    wb_o.reg_addr = item_i.reg_a;
    wb_o.reg_data = res;
    wb_o.flag_we  = active;
    wb_o.flags    = nf;
  end

endmodule

### rtl/comet2_execute_unit.sv
// Execute stage of a 16-bit teaching machine: eight general registers and
// the overflow, sign and zero flags, one decoded instruction per beat.
//
// Input channel in_valid_i/in_ready_o carries one instruction beat; output
// channel out_valid_o/out_ready_i carries one result beat per instruction.
// The APB port holds mem_size at byte address 0; pready is tied high.
//
// Pipeline: at the accepting edge both register operands are captured in the
// registered read port of the register file along with the instruction;
// the operand stage then runs the address add, range check and ALU, and
// writes back registers and flags as the result is captured, once the
// result register is free or being drained.
// Throughput: one instruction per cycle while out_ready_i stays high, with the
// write-back forwarded into the read port of the instruction behind it.
//
// Reset makes all registers read as zero, clears the flags and sets mem_size to
// 65536. When the receiver stalls, the result register holds its beat and
// one more instruction is taken into the operand stage before in_ready_o
// drops.
module comet2_execute_unit #(
  parameter int REG_COUNT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  c2eu_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output c2eu_pkg::out_beat_t out_beat_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                s1_valid_q;
  c2eu_pkg::in_beat_t  s1_q;
  logic                out_valid_q;
  c2eu_pkg::out_beat_t out_q;
  logic [16:0]         mem_size_q;
  c2eu_pkg::flags_t    flags_q;

  logic                accept, fire;
  logic [15:0]         ra_val, rb_val;
  c2eu_pkg::out_beat_t res;
  c2eu_pkg::wb_t       wb, wb_fire;

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    wb_fire        = wb;
    wb_fire.reg_we = wb.reg_we && fire;
  end

  c2eu_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .ra_addr_i (in_beat_i.reg_a),
    .rb_addr_i (in_beat_i.reg_b),
    .wb_i      (wb_fire),
    .ra_data_o (ra_val),
    .rb_data_o (rb_val)
  );

  c2eu_alu #(
    .REG_COUNT(REG_COUNT)
  ) u_alu (
    .item_i     (s1_q),
    .ra_val_i   (ra_val),
    .rb_val_i   (rb_val),
    .flags_i    (flags_q),
    .mem_size_i (mem_size_q),
    .res_o      (res),
    .wb_o       (wb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      mem_size_q  <= c2eu_pkg::MEM_SIZE_RST;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire && wb.flag_we) begin
        flags_q <= wb.flags;
      end
      if (psel && penable && pwrite && (paddr[2] == c2eu_pkg::ADDR_MEM_SIZE)) begin
        mem_size_q <= pwdata[16:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_beat_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == c2eu_pkg::ADDR_MEM_SIZE) ? {15'h0000, mem_size_q} : '0;

endmodule

### rtl/c2eu_checker.sv
module c2eu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input c2eu_pkg::out_beat_t out_beat_o,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_err_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.error_code != c2eu_pkg::ERR_NONE) |->
      !out_beat_o.reg_written && !out_beat_o.branch_taken &&
      (out_beat_o.result_value == 16'h0000))
    else $error("faulting instruction had an effect");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind comet2_execute_unit c2eu_checker u_checker (.*);
